// File: design/cmbenum_pkg.sv
// Shared types and constants of the combination enumerator.
// No dependencies; every other file of the block imports it.
`default_nettype none

package cmbenum_pkg;

   localparam int DEF_MAX_SET    = 64;
   localparam int DEF_MAX_CHOOSE = 16;

   // wide enough for set size, choose count and limits over the parameter ranges
   localparam int CMP_W = 10;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_ADDR_W-1:0] CSR_SET_SIZE     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHOOSE_COUNT = 2'd1;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_NEXT    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] STAT_ELEMENT = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_DONE    = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] symbol_slot;
      logic [7:0] symbol_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] element_index;
      logic [7:0] element_symbol;
      logic [3:0] slot_in_combination;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_NEXT,
      OP_RESTART
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] slot;
      logic [7:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STATUS,
      S_READ,
      S_CHECK,
      S_EMIT,
      S_ADVANCE,
      S_FILL
   } state_type;

endpackage

`default_nettype wire

// File: design/combination_enumerator_top.sv
// Top level of the combination enumerator: configuration registers, front end and back end.
// A next request walks the position memory, emitting its elements in order, and then refills
// the successor positions; the back end takes the next command only after returning to idle.
// Loads and restarts are carried out in the back end's idle state; status results are registered.
// Reset: synchronous; registers zero, identity positions and a zero symbol table at once.
`default_nettype none

module combination_enumerator_top #(
   parameter int MAX_SET    = cmbenum_pkg::DEF_MAX_SET,
   parameter int MAX_CHOOSE = cmbenum_pkg::DEF_MAX_CHOOSE
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  cmbenum_pkg::req_type                      req_data,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output cmbenum_pkg::rsp_type                      rsp_data,
   input  wire                                       csr_we,
   input  wire [cmbenum_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire [cmbenum_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import cmbenum_pkg::*;

   logic [6:0] set_size_ff, set_size_in;
   logic [4:0] choose_count_ff, choose_count_in;
   logic       cfg_restart;
   logic       q_valid;
   logic       q_pop;
   cmd_type    q_head;
   logic       bk_exhausted;

   always_comb begin
      set_size_in     = set_size_ff;
      choose_count_in = choose_count_ff;
      cfg_restart     = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SET_SIZE: begin
               set_size_in = csr_wdata[6:0];
               cfg_restart = 1'b1;
            end
            CSR_CHOOSE_COUNT: begin
               choose_count_in = csr_wdata[4:0];
               cfg_restart     = 1'b1;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff     <= '0;
         choose_count_ff <= '0;
      end else begin
         set_size_ff     <= set_size_in;
         choose_count_ff <= choose_count_in;
      end
   end

   cmbenum_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   cmbenum_back #(
      .MAX_SET    (MAX_SET),
      .MAX_CHOOSE (MAX_CHOOSE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg_restart  (cfg_restart),
      .set_size     (set_size_ff),
      .choose_count (choose_count_ff),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .bk_exhausted (bk_exhausted)
   );

   a_stall_means_queued: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_valid)
      else $error("input stalled with no queued command");

   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_addr == CSR_SET_SIZE || csr_addr == CSR_CHOOSE_COUNT)
      |=> !bk_exhausted)
      else $error("configuration write did not restart the enumeration");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_ELEMENT
      |-> rsp_data.last && rsp_data.element_index == '0 && rsp_data.element_symbol == '0)
      else $error("status result is not a lone cleared result");

endmodule

`default_nettype wire

// File: design/cmbenum_front.sv
// Front end: accepts requests, classifies them and queues commands.
// Depends on cmbenum_pkg.
`default_nettype none

module cmbenum_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  cmbenum_pkg::req_type  req_data,
   output logic                  q_valid,
   output cmbenum_pkg::cmd_type  q_head,
   input  wire                   q_pop
);
   import cmbenum_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push;
   logic                pop;
   cmd_type             cmd;

   assign req_stall = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_head    = q_mem_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      cmd.slot  = req_data.symbol_slot;
      cmd.value = req_data.symbol_value;
      cmd.op    = OP_LOAD;
      push      = 1'b0;
      unique case (req_data.kind)
         KIND_LOAD: begin
            cmd.op = OP_LOAD;
            push   = req_valid && !req_stall;
         end
         KIND_NEXT: begin
            cmd.op = OP_NEXT;
            push   = req_valid && !req_stall;
         end
         KIND_RESTART: begin
            cmd.op = OP_RESTART;
            push   = req_valid && !req_stall;
         end
         default: begin
            // drop unused kind
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

// File: design/cmbenum_back.sv
// Back end: sequencer that emits combinations, searches and refills positions.
// Holds the position and symbol memories and the result register.
// Depends on cmbenum_pkg.
`default_nettype none

module cmbenum_back #(
   parameter int MAX_SET    = cmbenum_pkg::DEF_MAX_SET,
   parameter int MAX_CHOOSE = cmbenum_pkg::DEF_MAX_CHOOSE
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cfg_restart,
   input  wire [6:0]             set_size,
   input  wire [4:0]             choose_count,
   input  wire                   q_valid,
   input  cmbenum_pkg::cmd_type  q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output cmbenum_pkg::rsp_type  rsp_data,
   output logic                  bk_exhausted
);
   import cmbenum_pkg::*;

   localparam int POS_W = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
   localparam int IDX_W = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
   localparam int CNT_W = IDX_W + 1;

   state_type           state_ff, state_in;
   logic                exh_ff, exh_in;
   logic [IDX_W-1:0]    elem_ff, elem_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    found_idx_ff, found_idx_in;
   logic [POS_W-1:0]    found_val_ff, found_val_in;
   logic [POS_W-1:0]    cur_pos_ff, cur_pos_in;
   logic [CNT_W-1:0]    fill_idx_ff, fill_idx_in;
   logic [POS_W-1:0]    fill_val_ff, fill_val_in;
   logic [1:0]          stat_code_ff, stat_code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [MAX_CHOOSE-1:0] pos_vld_ff, pos_vld_in;
   logic [MAX_SET-1:0]    sym_vld_ff, sym_vld_in;

   logic [POS_W-1:0]    pos_mem [MAX_CHOOSE];
   logic [POS_W-1:0]    pos_rd_ff;
   logic                pos_rd_vld_ff;
   logic [7:0]          sym_mem [MAX_SET];
   logic [7:0]          sym_rd_ff;
   logic                sym_rd_vld_ff;

   logic                pos_we;
   logic [IDX_W-1:0]    pos_waddr;
   logic [POS_W-1:0]    pos_wdata;
   logic                sym_we;
   logic [POS_W-1:0]    sym_waddr;
   logic [7:0]          sym_wdata;
   logic [POS_W-1:0]    sym_raddr;

   logic [CMP_W-1:0]    set_ext, n_eff, k_ext, limit, slot_ext;
   logic [POS_W-1:0]    pos_val;
   logic [7:0]          sym_val;
   logic                out_free;
   logic                is_last;
   logic                restart;

   assign set_ext  = CMP_W'(set_size);
   assign n_eff    = (set_ext > CMP_W'(MAX_SET)) ? CMP_W'(MAX_SET) : set_ext;
   assign k_ext    = CMP_W'(choose_count);
   assign slot_ext = CMP_W'(q_head.slot);
   assign pos_val  = pos_rd_vld_ff ? pos_rd_ff : POS_W'(CMP_W'(elem_ff));
   assign limit    = n_eff - k_ext + CMP_W'(elem_ff);
   assign sym_val  = sym_rd_vld_ff ? sym_rd_ff : 8'd0;
   assign sym_raddr = (state_ff == S_CHECK) ? pos_val : cur_pos_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last  = (CMP_W'(elem_ff) + CMP_W'(1)) == k_ext;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign bk_exhausted = exh_ff;

   always_comb begin
      state_in     = state_ff;
      exh_in       = exh_ff;
      elem_in      = elem_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_val_in = found_val_ff;
      cur_pos_in   = cur_pos_ff;
      fill_idx_in  = fill_idx_ff;
      fill_val_in  = fill_val_ff;
      stat_code_in = stat_code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pos_vld_in   = pos_vld_ff;
      sym_vld_in   = sym_vld_ff;
      q_pop        = 1'b0;
      pos_we       = 1'b0;
      pos_waddr    = elem_ff;
      pos_wdata    = fill_val_ff;
      sym_we       = 1'b0;
      sym_waddr    = POS_W'(slot_ext);
      sym_wdata    = q_head.value;
      restart      = cfg_restart;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_head.op)
                  OP_LOAD: begin
                     sym_we = (slot_ext < CMP_W'(MAX_SET));
                  end
                  OP_RESTART: begin
                     restart = 1'b1;
                  end
                  OP_NEXT: begin
                     if ((k_ext > CMP_W'(MAX_CHOOSE)) || (k_ext > n_eff) || exh_ff) begin
                        stat_code_in = STAT_DONE;
                        state_in     = S_STATUS;
                     end else if (k_ext == '0) begin
                        stat_code_in = STAT_EMPTY;
                        exh_in       = 1'b1;
                        state_in     = S_STATUS;
                     end else begin
                        elem_in  = '0;
                        found_in = 1'b0;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.status              = stat_code_ff;
               rsp_data_in.element_index       = '0;
               rsp_data_in.element_symbol      = '0;
               rsp_data_in.slot_in_combination = '0;
               rsp_data_in.last                = 1'b1;
               state_in                        = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cur_pos_in = pos_val;
            if (CMP_W'(pos_val) < limit) begin
               found_in     = 1'b1;
               found_idx_in = elem_ff;
               found_val_in = pos_val;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.status              = STAT_ELEMENT;
               rsp_data_in.element_index       = 6'(CMP_W'(cur_pos_ff));
               rsp_data_in.element_symbol      = sym_val;
               rsp_data_in.slot_in_combination = 4'(CMP_W'(elem_ff));
               rsp_data_in.last                = is_last;
               if (is_last) begin
                  state_in = S_ADVANCE;
               end else begin
                  elem_in  = elem_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_ADVANCE: begin
            if (found_ff) begin
               pos_we      = 1'b1;
               pos_waddr   = found_idx_ff;
               pos_wdata   = found_val_ff + 1'b1;
               fill_val_in = found_val_ff + 1'b1;
               fill_idx_in = CNT_W'(found_idx_ff) + 1'b1;
               state_in    = S_FILL;
            end else begin
               exh_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            if (CMP_W'(fill_idx_ff) < k_ext) begin
               pos_we      = 1'b1;
               pos_waddr   = fill_idx_ff[IDX_W-1:0];
               pos_wdata   = fill_val_ff + 1'b1;
               fill_val_in = fill_val_ff + 1'b1;
               fill_idx_in = fill_idx_ff + 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (pos_we) begin
         pos_vld_in[pos_waddr] = 1'b1;
      end
      if (sym_we) begin
         sym_vld_in[sym_waddr] = 1'b1;
      end
      if (restart) begin
         pos_vld_in = '0;
         exh_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         exh_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_vld_ff   <= '0;
         sym_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         exh_ff       <= exh_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_vld_ff   <= pos_vld_in;
         sym_vld_ff   <= sym_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff      <= elem_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      found_val_ff <= found_val_in;
      cur_pos_ff   <= cur_pos_in;
      fill_idx_ff  <= fill_idx_in;
      fill_val_ff  <= fill_val_in;
      stat_code_ff <= stat_code_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff     <= pos_mem[elem_ff];
      pos_rd_vld_ff <= pos_vld_ff[elem_ff];
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_waddr] <= sym_wdata;
      end
      sym_rd_ff     <= sym_mem[sym_raddr];
      sym_rd_vld_ff <= sym_vld_ff[sym_raddr];
   end

endmodule

`default_nettype wire
